@@ hw/rtl/pesb_pkg.sv @@
package pesb_pkg;

    localparam int FixedW = 16;
    localparam int WordW  = 32;
    localparam int ModeW  = 3;

    // Operation codes carried in the mode field of an input item.
    localparam logic [ModeW-1:0] MODE_RAISE   = 3'd0;
    localparam logic [ModeW-1:0] MODE_SERVICE = 3'd1;
    localparam logic [ModeW-1:0] MODE_WR_FEN  = 3'd2;
    localparam logic [ModeW-1:0] MODE_WR_GEN  = 3'd3;
    localparam logic [ModeW-1:0] MODE_COLLECT = 3'd4;

    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic [FixedW-1:0] fixed_raise;
        logic [WordW-1:0]  general_raise;
        logic [WordW-1:0]  write_value;
    } in_item_t;

    typedef struct packed {
        logic              sci_request;
        logic              sci_enabled;
        logic [FixedW-1:0] fixed_enable_now;
        logic [WordW-1:0]  general_enable_now;
        logic [FixedW-1:0] fixed_events;
        logic [WordW-1:0]  general_events;
        logic              events_valid;
    } out_item_t;

endpackage

@@ hw/rtl/power_event_status_enable_block.sv @@
// Power-management event block: fixed and general-purpose event status
// words, their enable words, an SCI-enable flag and sticky event latches.
//
// Input channel (in_valid, in_stall, in_item): each item carries a mode
// (raise, service, write fixed enable, write general enable, collect) and
// its operands. An item is taken at a clock edge where in_valid is high and
// in_stall is low. Every item produces exactly one result item.
// Output channel (out_valid, out_stall, out_item): the result is held in a
// single output register and appears in the cycle after its item is taken.
// The state update and the result are computed in one pass of mask logic
// between the input port and the state and result registers, so one item
// is taken in every cycle while the receiver keeps taking results.
// When the receiver stalls a waiting result, in_stall rises in the same
// cycle and the held result stays unchanged until it is taken.
// Configuration: cfg_we writes cfg_wdata into the level-trigger mask. The user
// must write it only while the block is idle; the block itself does not enforce this.
// Reset (rst_n, asynchronous, active low) clears all status, enable, latch
// and SCI state, the level mask and the output valid flag.
module power_event_status_enable_block #(
    parameter int GENERAL_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pesb_pkg::WordW-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pesb_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pesb_pkg::out_item_t           out_item
);

    // Working width that holds both a port word and a general word.
    localparam int WideW = (GENERAL_BITS > pesb_pkg::WordW) ? GENERAL_BITS : pesb_pkg::WordW;

    logic [pesb_pkg::WordW-1:0]  level_mask_reg;
    logic [pesb_pkg::FixedW-1:0] fixed_status_reg, fixed_status_next;
    logic [pesb_pkg::FixedW-1:0] fixed_enable_reg, fixed_enable_next;
    logic [pesb_pkg::FixedW-1:0] fixed_latch_reg, fixed_latch_next;
    logic [GENERAL_BITS-1:0]     general_status_reg, general_status_next;
    logic [GENERAL_BITS-1:0]     general_enable_reg, general_enable_next;
    logic [GENERAL_BITS-1:0]     general_latch_reg, general_latch_next;
    logic                        sci_on_reg, sci_on_next;
    logic                        out_valid_reg, out_valid_next;
    pesb_pkg::out_item_t         out_item_reg, out_item_next;

    logic                        accept;
    logic [WideW-1:0]            raise_wide, wval_wide, level_wide;
    logic [WideW-1:0]            gen_enable_wide, gen_latch_wide;
    logic [GENERAL_BITS-1:0]     graise, gwval, glevel;

    // A result waiting behind a stalled receiver blocks the input; otherwise
    // the output register is free or drains in this very cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Bring the 32-bit port words to the general word width.
    assign raise_wide = WideW'(in_item.general_raise);
    assign wval_wide  = WideW'(in_item.write_value);
    assign level_wide = WideW'(level_mask_reg);
    assign graise     = raise_wide[GENERAL_BITS-1:0];
    assign gwval      = wval_wide[GENERAL_BITS-1:0];
    assign glevel     = level_wide[GENERAL_BITS-1:0];

    always_comb
    begin
        logic [pesb_pkg::FixedW-1:0] ftaken;
        logic [pesb_pkg::FixedW-1:0] fval;
        logic [GENERAL_BITS-1:0]     gtaken;
        logic [GENERAL_BITS-1:0]     glvl;
        logic                        collect;

        ftaken = fixed_status_reg & fixed_enable_reg;
        gtaken = general_status_reg & general_enable_reg;
        glvl   = gtaken & glevel;
        fval   = in_item.write_value[pesb_pkg::FixedW-1:0];
        collect = 1'b0;

        fixed_status_next   = fixed_status_reg;
        fixed_enable_next   = fixed_enable_reg;
        fixed_latch_next    = fixed_latch_reg;
        general_status_next = general_status_reg;
        general_enable_next = general_enable_reg;
        general_latch_next  = general_latch_reg;
        sci_on_next         = sci_on_reg;

        unique case (in_item.mode)
            pesb_pkg::MODE_RAISE:
            begin
                fixed_status_next   = fixed_status_reg | in_item.fixed_raise;
                general_status_next = general_status_reg | graise;
            end
            pesb_pkg::MODE_SERVICE:
            begin
                // Level events are masked off; edge events are acknowledged.
                fixed_status_next   = fixed_status_reg & ~ftaken;
                general_enable_next = general_enable_reg & ~glvl;
                general_status_next = general_status_reg & ~(gtaken & ~glvl);
                fixed_latch_next    = fixed_latch_reg | ftaken;
                general_latch_next  = general_latch_reg | gtaken;
            end
            pesb_pkg::MODE_WR_FEN:
            begin
                fixed_status_next = fixed_status_reg & ~(fval & ~fixed_enable_reg);
                if (fval != '0)
                begin
                    sci_on_next = 1'b1;
                end
                else if (general_enable_reg == '0 && sci_on_reg)
                begin
                    fixed_status_next   = '0;
                    general_status_next = '0;
                    general_enable_next = '0;
                    sci_on_next         = 1'b0;
                end
                fixed_enable_next = fval;
            end
            pesb_pkg::MODE_WR_GEN:
            begin
                general_status_next = general_status_reg & ~(gwval & ~general_enable_reg);
                if (gwval != '0)
                begin
                    sci_on_next = 1'b1;
                end
                else if (fixed_enable_reg == '0 && sci_on_reg)
                begin
                    fixed_status_next   = '0;
                    general_status_next = '0;
                    fixed_enable_next   = '0;
                    sci_on_next         = 1'b0;
                end
                general_enable_next = gwval;
            end
            pesb_pkg::MODE_COLLECT:
            begin
                collect            = 1'b1;
                fixed_latch_next   = '0;
                general_latch_next = '0;
            end
            default:
            begin
                // Unused codes leave the state alone and report it.
            end
        endcase

        gen_enable_wide = WideW'(general_enable_next);
        gen_latch_wide  = WideW'(general_latch_reg);

        out_item_next.sci_request = sci_on_next &&
            (((fixed_status_next & fixed_enable_next) != '0) ||
             ((general_status_next & general_enable_next) != '0));
        out_item_next.sci_enabled        = sci_on_next;
        out_item_next.fixed_enable_now   = fixed_enable_next;
        out_item_next.general_enable_now = gen_enable_wide[pesb_pkg::WordW-1:0];
        out_item_next.fixed_events       = collect ? fixed_latch_reg : '0;
        out_item_next.general_events     = collect ? gen_latch_wide[pesb_pkg::WordW-1:0] : '0;
        out_item_next.events_valid       = collect &&
            (fixed_latch_reg != '0 || general_latch_reg != '0);

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_mask_reg     <= '0;
            fixed_status_reg   <= '0;
            fixed_enable_reg   <= '0;
            fixed_latch_reg    <= '0;
            general_status_reg <= '0;
            general_enable_reg <= '0;
            general_latch_reg  <= '0;
            sci_on_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                level_mask_reg <= cfg_wdata;
            end
            if (accept)
            begin
                fixed_status_reg   <= fixed_status_next;
                fixed_enable_reg   <= fixed_enable_next;
                fixed_latch_reg    <= fixed_latch_next;
                general_status_reg <= general_status_next;
                general_enable_reg <= general_enable_next;
                general_latch_reg  <= general_latch_next;
                sci_on_reg         <= sci_on_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register: loads only when an item is taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // With SCI off, both enable words must be zero: SCI only drops on shutdown.
    a_sci_off_no_enables: assert property (@(posedge clk) disable iff (!rst_n)
        !sci_on_reg |-> (fixed_enable_reg == '0 && general_enable_reg == '0))
        else $error("enable bits set while SCI is off");

    // A taken collect item empties both latches.
    a_collect_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_item.mode == pesb_pkg::MODE_COLLECT |=>
            (fixed_latch_reg == '0 && general_latch_reg == '0))
        else $error("latches not cleared by collect");

    // Every taken item leaves a result in the output register.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("taken item produced no result");

    // An SCI request is only ever reported with SCI enabled.
    a_request_needs_sci: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_item_reg.sci_request || out_item_reg.sci_enabled))
        else $error("SCI request without SCI enable");

    // Nonzero collected event words always come with the events flag. The
    // flag alone may be set by general bits above the visible word.
    a_events_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.fixed_events != '0 ||
            out_item_reg.general_events != '0) |-> out_item_reg.events_valid)
        else $error("events_valid disagrees with event words");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the power-management event block.
//
// Every input item produces exactly one result item, so the bench keeps a
// queue of expected results. An item is predicted the moment it is put on
// the input channel, and results are checked in order as the receiver takes
// them. The prediction comes from a behavioral copy of the block's status,
// enable, SCI and latch state that lives in this module.
module tb_top;

    // Mode codes that the block does not decode. They must leave the state
    // alone and report it with empty event fields.
    localparam logic [pesb_pkg::ModeW-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [pesb_pkg::ModeW-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [pesb_pkg::ModeW-1:0] MODE_SPARE_7 = 3'd7;

    // Random items per configuration segment, after the directed table.
    localparam int RANDOM_PER_SEGMENT = 500;
    // Every so many random items the sender waits for the output to drain.
    localparam int DRAIN_EVERY = 150;

    // One row of the directed table. When has_want is set the expected
    // result is the typed-in value; otherwise the predictor supplies it.
    typedef struct packed {
        pesb_pkg::in_item_t  stim;
        logic                has_want;
        pesb_pkg::out_item_t want;
    } event_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [31:0]         cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    pesb_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall;
    pesb_pkg::out_item_t out_item;

    // Percentages of cycles in which the sender holds off and the receiver
    // stalls. The main sequence changes them between segments.
    int            send_idle_pct;
    int            recv_stall_pct;
    int            mismatch_count;

    // Results that the block still owes, oldest first.
    pesb_pkg::out_item_t pending_results[$];
    event_row_t          directed_rows[$];

    // Behavioral copy of the block's state.
    logic [15:0]   fx_status;
    logic [15:0]   fx_enable;
    logic [31:0]   gp_status;
    logic [31:0]   gp_enable;
    logic          sci_flag;
    logic [15:0]   fx_latch;
    logic [31:0]   gp_latch;
    logic [31:0]   level_bits;

    power_event_status_enable_block #(
        .GENERAL_BITS(32)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The run is bounded at 2 ms. The slowest correct run needs about 2025
    // items, even under the heaviest idling, and this bound leaves a margin
    // of well over ten times.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Prints one line for a failure and counts it.
    task automatic flag_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // The shutdown path clears both enables, both status words and the SCI
    // flag. The latches survive it.
    function automatic void clear_all_enables();
        fx_enable = '0;
        fx_status = '0;
        gp_enable = '0;
        gp_status = '0;
        sci_flag  = 1'b0;
    endfunction

    // Applies one item to the behavioral state and returns the result that
    // the block must produce for it.
    function automatic pesb_pkg::out_item_t advance_events(input pesb_pkg::in_item_t it);
        pesb_pkg::out_item_t r;
        logic [15:0] ftaken;
        logic [15:0] fv;
        logic [31:0] gtaken;
        logic [31:0] glevel;
        logic [31:0] gv;
        r = '0;
        case (it.mode)
            pesb_pkg::MODE_RAISE:
            begin
                fx_status |= it.fixed_raise;
                gp_status |= it.general_raise;
            end
            pesb_pkg::MODE_SERVICE:
            begin
                // Only bits that are both pending and enabled are taken.
                // Level-triggered general bits lose their enable instead of
                // their status, since the source keeps driving them.
                ftaken = fx_status & fx_enable;
                gtaken = gp_status & gp_enable;
                glevel = gtaken & level_bits;
                fx_status &= ~ftaken;
                gp_enable &= ~glevel;
                gp_status &= ~(gtaken & ~glevel);
                fx_latch  |= ftaken;
                gp_latch  |= gtaken;
            end
            pesb_pkg::MODE_WR_FEN:
            begin
                // Newly enabled bits drop any stale status first.
                fv = it.write_value[15:0];
                fx_status &= ~(fv & ~fx_enable);
                if (fv != '0)
                    sci_flag = 1'b1;
                else if (gp_enable == '0 && sci_flag)
                    clear_all_enables();
                fx_enable = fv;
            end
            pesb_pkg::MODE_WR_GEN:
            begin
                gv = it.write_value;
                gp_status &= ~(gv & ~gp_enable);
                if (gv != '0)
                    sci_flag = 1'b1;
                else if (fx_enable == '0 && sci_flag)
                    clear_all_enables();
                gp_enable = gv;
            end
            pesb_pkg::MODE_COLLECT:
            begin
                r.fixed_events   = fx_latch;
                r.general_events = gp_latch;
                r.events_valid   = (fx_latch != '0) || (gp_latch != '0);
                fx_latch = '0;
                gp_latch = '0;
            end
            default:
            begin
            end
        endcase
        r.sci_request = sci_flag &&
                        (((fx_status & fx_enable) != '0) || ((gp_status & gp_enable) != '0));
        r.sci_enabled        = sci_flag;
        r.fixed_enable_now   = fx_enable;
        r.general_enable_now = gp_enable;
        return r;
    endfunction

    // Builds a typed-in expectation for the directed table.
    function automatic pesb_pkg::out_item_t result_of(input logic sr, input logic se,
                                            input logic [15:0] fen, input logic [31:0] gen,
                                            input logic [15:0] fev, input logic [31:0] gev,
                                            input logic ev);
        pesb_pkg::out_item_t r;
        r.sci_request        = sr;
        r.sci_enabled        = se;
        r.fixed_enable_now   = fen;
        r.general_enable_now = gen;
        r.fixed_events       = fev;
        r.general_events     = gev;
        r.events_valid       = ev;
        return r;
    endfunction

    task automatic add_row(input logic [pesb_pkg::ModeW-1:0] m, input logic [15:0] fr,
                           input logic [31:0] gr, input logic [31:0] wv,
                           input logic has_want, input pesb_pkg::out_item_t want);
        event_row_t row;
        row.stim.mode          = m;
        row.stim.fixed_raise   = fr;
        row.stim.general_raise = gr;
        row.stim.write_value   = wv;
        row.has_want           = has_want;
        row.want               = want;
        directed_rows.push_back(row);
    endtask

    // Random words lean toward the patterns that matter for mask logic:
    // empty, full, single bits, sparse and dense words.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(31);
            3:       return $urandom & $urandom;
            4:       return ~($urandom & $urandom);
            default: return $urandom;
        endcase
    endfunction

    // Half of the random items are raise and service steps so that status builds
    // up and gets taken. Enable writes are zero now and then, which drives
    // the shutdown path. Unused fields always carry noise.
    function automatic pesb_pkg::in_item_t random_event_item();
        pesb_pkg::in_item_t it;
        int                 pick;
        it.fixed_raise   = 16'(rand_word());
        it.general_raise = rand_word();
        it.write_value   = rand_word();
        pick = $urandom_range(99);
        if (pick < 30)
            it.mode = pesb_pkg::MODE_RAISE;
        else if (pick < 50)
            it.mode = pesb_pkg::MODE_SERVICE;
        else if (pick < 62)
            it.mode = pesb_pkg::MODE_WR_FEN;
        else if (pick < 74)
            it.mode = pesb_pkg::MODE_WR_GEN;
        else if (pick < 93)
            it.mode = pesb_pkg::MODE_COLLECT;
        else
            it.mode = 3'($urandom_range(7, 5));
        if (it.mode == pesb_pkg::MODE_WR_FEN && $urandom_range(3) == 0)
            it.write_value[15:0] = '0;
        if (it.mode == pesb_pkg::MODE_WR_GEN && $urandom_range(3) == 0)
            it.write_value = '0;
        return it;
    endfunction

    // Puts one item on the input channel, starting at a falling edge, and
    // returns at the falling edge after the item was taken. The sender may
    // hold off at random first. The prediction is queued right away;
    // the block answers items in order, so its result cannot come earlier.
    task automatic send_item(input pesb_pkg::in_item_t it, input logic has_want,
                             input pesb_pkg::out_item_t want);
        pesb_pkg::out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        predicted = advance_events(it);
        pending_results.push_back(has_want ? want : predicted);
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Lowers valid and waits until every queued result has been taken. The
    // wait always passes a falling edge, so valid never drops and rises in one step.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // The level mask may only change while nothing is in flight.
    task automatic write_level_mask(input logic [31:0] value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        level_bits = value;
    endtask

    // The receiver stalls at random, changing only at falling edges.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Results are taken at rising edges where valid is high and stall low.
    // Each is compared, field by field, with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        pesb_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result item arrived with nothing pending");
            else
            begin
                want = pending_results.pop_front();
                if (out_item.sci_request !== want.sci_request)
                    flag_mismatch($sformatf("sci_request got %0b want %0b",
                                            out_item.sci_request, want.sci_request));
                if (out_item.sci_enabled !== want.sci_enabled)
                    flag_mismatch($sformatf("sci_enabled got %0b want %0b",
                                            out_item.sci_enabled, want.sci_enabled));
                if (out_item.fixed_enable_now !== want.fixed_enable_now)
                    flag_mismatch($sformatf("fixed_enable_now got %h want %h",
                                            out_item.fixed_enable_now, want.fixed_enable_now));
                if (out_item.general_enable_now !== want.general_enable_now)
                    flag_mismatch($sformatf("general_enable_now got %h want %h",
                                            out_item.general_enable_now,
                                            want.general_enable_now));
                if (out_item.fixed_events !== want.fixed_events)
                    flag_mismatch($sformatf("fixed_events got %h want %h",
                                            out_item.fixed_events, want.fixed_events));
                if (out_item.general_events !== want.general_events)
                    flag_mismatch($sformatf("general_events got %h want %h",
                                            out_item.general_events, want.general_events));
                if (out_item.events_valid !== want.events_valid)
                    flag_mismatch($sformatf("events_valid got %0b want %0b",
                                            out_item.events_valid, want.events_valid));
            end
        end
    end

    initial
    begin : main_sequence
        logic [31:0] segment_mask [4];
        int          segment_send [4];
        int          segment_recv [4];
        // All block inputs and the behavioral state start known.
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_stall      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        fx_status      = '0;
        fx_enable      = '0;
        gp_status      = '0;
        gp_enable      = '0;
        sci_flag       = 1'b0;
        fx_latch       = '0;
        gp_latch       = '0;
        level_bits     = '0;

        // Four configuration segments. The first has a heavy receiver, the
        // second a heavy sender, and the last two run with no idling at all.
        // The mask moves between half, all, none and a random pattern.
        segment_mask[0] = 32'hFFFF_0000;
        segment_mask[1] = 32'hFFFF_FFFF;
        segment_mask[2] = 32'h0000_0000;
        segment_mask[3] = $urandom;
        segment_send[0] = 32;
        segment_recv[0] = 55;
        segment_send[1] = 55;
        segment_recv[1] = 32;
        segment_send[2] = 0;
        segment_recv[2] = 0;
        segment_send[3] = 0;
        segment_recv[3] = 0;

        // Directed table, run with the upper half of the general word level
        // triggered. The first rows start from reset, where everything reads
        // zero, so their results are typed in.
        add_row(MODE_SPARE_5, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                result_of(1'b0, 1'b0, 16'h0, 32'h0, 16'h0, 32'h0, 1'b0));
        // Collect with empty latches, then a service step while SCI is off.
        add_row(pesb_pkg::MODE_COLLECT, 16'h0, 32'h0, 32'h0, 1'b1,
                result_of(1'b0, 1'b0, 16'h0, 32'h0, 16'h0, 32'h0, 1'b0));
        add_row(pesb_pkg::MODE_SERVICE, 16'h0, 32'h0, 32'h0, 1'b1,
                result_of(1'b0, 1'b0, 16'h0, 32'h0, 16'h0, 32'h0, 1'b0));
        // Raising everything with nothing enabled requests nothing.
        add_row(pesb_pkg::MODE_RAISE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1'b1,
                result_of(1'b0, 1'b0, 16'h0, 32'h0, 16'h0, 32'h0, 1'b0));
        // Enabling all fixed bits wipes their stale status and turns SCI on.
        // Only the low half of the written word counts.
        add_row(pesb_pkg::MODE_WR_FEN, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b1,
                result_of(1'b0, 1'b1, 16'hFFFF, 32'h0, 16'h0, 32'h0, 1'b0));
        add_row(pesb_pkg::MODE_RAISE, 16'h8001, 32'h0, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_WR_GEN, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(pesb_pkg::MODE_RAISE, 16'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, '0);
        // Service takes both words; level bits lose their enables.
        add_row(pesb_pkg::MODE_SERVICE, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_COLLECT, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_COLLECT, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_RAISE, 16'h0, 32'h0001_0001, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_SERVICE, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        // A zero fixed write while general enables remain only clears the
        // fixed enable. The zero general write that follows shuts the block
        // down, and a second one with SCI off changes nothing but the enable.
        add_row(pesb_pkg::MODE_WR_FEN, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_WR_GEN, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_WR_GEN, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_WR_FEN, 16'h0, 32'h0, 32'hABCD_0000, 1'b0, '0);
        add_row(MODE_SPARE_6, 16'h5A5A, 32'hA5A5_A5A5, 32'h1234_5678, 1'b0, '0);
        add_row(MODE_SPARE_7, 16'hA5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(pesb_pkg::MODE_COLLECT, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        // Top bit only, then a zero fixed write that must not shut down.
        add_row(pesb_pkg::MODE_WR_GEN, 16'h0, 32'h0, 32'h8000_0000, 1'b0, '0);
        add_row(pesb_pkg::MODE_RAISE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_WR_FEN, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_SERVICE, 16'h0, 32'h0, 32'h0, 1'b0, '0);
        add_row(pesb_pkg::MODE_COLLECT, 16'h0, 32'h0, 32'h0, 1'b0, '0);

        // Reset is held low from time zero and released at a falling edge.
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (int seg = 0; seg < 4; seg++)
        begin
            write_level_mask(segment_mask[seg]);
            send_idle_pct  = segment_send[seg];
            recv_stall_pct = segment_recv[seg];
            if (seg == 0)
            begin
                foreach (directed_rows[i])
                    send_item(directed_rows[i].stim, directed_rows[i].has_want,
                              directed_rows[i].want);
            end
            for (int n = 0; n < RANDOM_PER_SEGMENT; n++)
            begin
                // Now and then the sender waits for the output to drain.
                if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                    wait_for_results();
                send_item(random_event_item(), 1'b0, '0);
            end
        end

        // Drain, then keep the checker running past the last result, so that a stray
        // result would still be caught.
        wait_for_results();
        repeat (4) @(negedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/pesb_pkg.sv
hw/rtl/power_event_status_enable_block.sv
test/tb_top.sv
